FILE: hw/rtl/obd_response_line_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the response line decoder
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef OBD_RESPONSE_LINE_DECODER_UNIT_DEFINES_SVH
`define OBD_RESPONSE_LINE_DECODER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define OBD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define OBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define OBD_ASSERT_IMP(lbl, ante, cons, msg)
`define OBD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/obdrld_pkg.sv
// ----------------------------------------------------------------------------
// obdrld_pkg
// Character codes, quantity codes and decode helpers for the line decoder.
// ----------------------------------------------------------------------------
package obdrld_pkg;

	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_LF     = 8'h0A;
	localparam logic [7:0] CHAR_PROMPT = 8'h3E;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_TAB    = 8'h09;
	localparam logic [7:0] CHAR_VT     = 8'h0B;
	localparam logic [7:0] CHAR_FF     = 8'h0C;
	localparam logic [7:0] CHAR_4      = 8'h34;
	localparam logic [7:0] CHAR_1      = 8'h31;

	localparam int KEEP_CHARS = 8;
	localparam int NUM_PIDS   = 14;
	localparam logic [3:0] LEN_MAX  = 4'd15;
	localparam logic [3:0] LEN_MIN  = 4'd6;
	localparam logic [3:0] LEN_FULL = 4'd8;

	typedef enum logic [3:0] {
		QTY_RPM      = 4'd0,
		QTY_SPEED    = 4'd1,
		QTY_COOLANT  = 4'd2,
		QTY_INTAKE   = 4'd3,
		QTY_THROTTLE = 4'd4,
		QTY_LOAD     = 4'd5,
		QTY_MAP      = 4'd6,
		QTY_FUEL     = 4'd7,
		QTY_TIMING   = 4'd8,
		QTY_GEAR     = 4'd9,
		QTY_VOLT     = 4'd10,
		QTY_DEMAND   = 4'd11,
		QTY_TORQUE   = 4'd12,
		QTY_RATE     = 4'd13
	} quantity_t;

	typedef struct packed {
		logic      hit;
		quantity_t qty;
	} pid_match_t;

	// PID code pairs, index equals the quantity code
	localparam logic [15:0] PID_CODES [NUM_PIDS] = '{
		16'h3043, 16'h3044, 16'h3035, 16'h3046, 16'h3131, 16'h3034, 16'h3042,
		16'h3246, 16'h3045, 16'h4134, 16'h3432, 16'h3631, 16'h3632, 16'h3545
	};

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
	endfunction

	function automatic logic is_term(input logic [7:0] c);
		return (c == CHAR_CR) || (c == CHAR_LF) || (c == CHAR_PROMPT);
	endfunction

	// non-hex digits count as zero
	function automatic logic [3:0] hex_digit(input logic [7:0] c);
		logic [3:0] d;
		d = 4'd0;
		if (c >= 8'h30 && c <= 8'h39)
			d = c[3:0];
		else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
			d = c[3:0] + 4'd9;
		return d;
	endfunction

	function automatic logic [7:0] hex_byte(input logic [7:0] hi, input logic [7:0] lo);
		return {hex_digit(hi), hex_digit(lo)};
	endfunction

	function automatic pid_match_t pid_lookup(input logic [7:0] c0, input logic [7:0] c1);
		pid_match_t m;
		m.hit = 1'b0;
		m.qty = QTY_RPM;
		for (int k = 0; k < NUM_PIDS; k++) begin
			if ({c0, c1} == PID_CODES[k]) begin
				m.hit = 1'b1;
				m.qty = quantity_t'(k[3:0]);
			end
		end
		return m;
	endfunction

endpackage

FILE: hw/rtl/obdrld_if.sv
// ----------------------------------------------------------------------------
// obdrld channel interfaces
// Character channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface obdrld_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink   (input valid, input char_in, output ready);
endinterface

interface obdrld_res_if;
	logic               valid;
	logic               ready;
	logic [3:0]         quantity;
	logic signed [15:0] value;

	modport source (output valid, output quantity, output value, input ready);
	modport sink   (input valid, input quantity, input value, output ready);
endinterface

FILE: hw/rtl/obdrld_scale.sv
// ----------------------------------------------------------------------------
// obdrld_scale
// Turns the quantity code and data bytes A, B into the scaled reading.
// ----------------------------------------------------------------------------
module obdrld_scale (
	input  obdrld_pkg::quantity_t qty,
	input  logic [7:0]            a,
	input  logic [7:0]            b,
	output logic signed [15:0]    value
);
	import obdrld_pkg::*;

	localparam logic [17:0] RECIP_100 = 18'd167773; // ceil(2^24 / 100)

	logic [15:0]        ab;
	logic [14:0]        a_x100;
	logic [14:0]        pct_sum;
	logic [6:0]         pct;
	logic [33:0]        volt_prod;
	logic [9:0]         volt;
	logic signed [16:0] a_s;
	logic signed [16:0] res;

	assign ab        = {a, b};
	assign a_x100    = ({7'd0, a} << 6) + ({7'd0, a} << 5) + ({7'd0, a} << 2);
	// x / 255 exact for x = a * 100, which is at most 25500
	assign pct_sum   = a_x100 + {8'd0, a_x100[14:8]} + 15'd1;
	assign pct       = pct_sum[14:8];
	assign volt_prod = {18'd0, ab} * {16'd0, RECIP_100};
	assign volt      = volt_prod[33:24];
	assign a_s       = $signed({9'd0, a});

	always_comb begin
		unique case (qty)
			QTY_RPM:      res = $signed({3'd0, ab[15:2]});
			QTY_SPEED,
			QTY_MAP:      res = a_s;
			QTY_COOLANT,
			QTY_INTAKE:   res = a_s - 17'sd40;
			QTY_THROTTLE,
			QTY_LOAD,
			QTY_FUEL:     res = $signed({10'd0, pct});
			QTY_TIMING:   res = $signed({10'd0, a[7:1]}) - 17'sd64;
			QTY_GEAR:     res = $signed({13'd0, a[3:0]});
			QTY_VOLT:     res = $signed({7'd0, volt});
			QTY_DEMAND,
			QTY_TORQUE:   res = a_s - 17'sd125;
			QTY_RATE:     res = $signed({2'd0, ab[15:1]});
			default:      res = 17'sd0;
		endcase
	end

	assign value = res[15:0];

endmodule

FILE: hw/rtl/obd_response_line_decoder_unit.sv
// ----------------------------------------------------------------------------
// obd_response_line_decoder_unit
// Decodes OBD-II mode 01 response lines, one ASCII character per word.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                      meaning
//  char_ch   in   char_in[7:0]                 one received character
//  res_ch    out  quantity[3:0], value[15:0]   one scaled reading per decoded line
//
//  One character is taken every cycle unless both stages are full. A
//  terminator (CR, LF, '>') that closes a decodable line yields a result
//  on res_ch via line decode into _s1, then scaling multiply into _s2.
//  Reset clears the line state and both stage valids; stored characters
//  are not reset since only entries written in the current line are read.
//  A stalled result holds in _s2 while _s1 still takes one more word; the
//  character side stalls only when both stages are full.
//
module obd_response_line_decoder_unit (
	input  logic             clk,
	input  logic             arst_n,
	obdrld_char_if.sink      char_ch,
	obdrld_res_if.source     res_ch
);
	import obdrld_pkg::*;

	`include "obd_response_line_decoder_unit_defines.svh"

	// line state
	logic       seen_q;
	logic [7:0] chars_q [KEEP_CHARS];
	logic [3:0] char_count_q;
	logic [3:0] content_len_q;

	// pipeline
	logic       valid_s1;
	quantity_t  qty_s1;
	logic [7:0] a_s1;
	logic [7:0] b_s1;

	logic               valid_s2;
	quantity_t          qty_s2;
	logic signed [15:0] value_s2;

	logic               in_acc;
	logic               in_term;
	logic               in_blank;
	logic               take_char;
	logic [3:0]         count_next;
	logic               s2_load;
	logic               s1_free;
	pid_match_t         pid;
	logic               dec_ok;
	logic signed [15:0] scaled;

	assign in_term  = is_term(char_ch.char_in);
	assign in_blank = is_blank(char_ch.char_in);
	assign in_acc   = char_ch.valid && char_ch.ready;

	// drop leading blanks; everything else but a terminator is a line character
	assign take_char  = in_acc && !in_term && (seen_q || !in_blank);
	assign count_next = (char_count_q < LEN_MAX) ? char_count_q + 4'd1 : char_count_q;

	// stage handshake: advance s1 into s2 when s2 is empty or being taken
	assign s2_load = !valid_s2 || res_ch.ready;
	assign s1_free = !valid_s1 || s2_load;
	assign char_ch.ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q        <= 1'b0;
			char_count_q  <= 4'd0;
			content_len_q <= 4'd0;
		end else if (in_acc && in_term) begin
			seen_q        <= 1'b0;
			char_count_q  <= 4'd0;
			content_len_q <= 4'd0;
		end else if (take_char) begin
			seen_q       <= 1'b1;
			char_count_q <= count_next;
			if (!in_blank)
				content_len_q <= count_next;
		end
	end

	// keep only the first characters of the trimmed line
	always_ff @(posedge clk) begin
		if (take_char && !char_count_q[3])
			chars_q[char_count_q[2:0]] <= char_ch.char_in;
	end

	// line decode at the terminator
	assign pid    = pid_lookup(chars_q[2], chars_q[3]);
	assign dec_ok = seen_q && (content_len_q >= LEN_MIN) &&
		(chars_q[0] == CHAR_4) && (chars_q[1] == CHAR_1) && pid.hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_acc && in_term && dec_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && in_acc && in_term) begin
			qty_s1 <= pid.qty;
			a_s1   <= hex_byte(chars_q[4], chars_q[5]);
			b_s1   <= (content_len_q >= LEN_FULL) ? hex_byte(chars_q[6], chars_q[7]) : 8'd0;
		end
	end

	// scaling
	obdrld_scale u_scale (
		.qty   (qty_s1),
		.a     (a_s1),
		.b     (b_s1),
		.value (scaled)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load && valid_s1) begin
			qty_s2   <= qty_s1;
			value_s2 <= scaled;
		end
	end

	assign res_ch.valid    = valid_s2;
	assign res_ch.quantity = qty_s2;
	assign res_ch.value    = value_s2;

	// checks
	`OBD_ASSERT_NEXT(a_term_clears, in_acc && in_term, !seen_q && char_count_q == 4'd0, "line state not cleared after terminator")
	`OBD_ASSERT_IMP(a_len_bound, 1'b1, content_len_q <= char_count_q, "content length exceeds character count")
	`OBD_ASSERT_IMP(a_idle_line, !seen_q, char_count_q == 4'd0 && content_len_q == 4'd0, "counts set without line content")
	`OBD_ASSERT_IMP(a_s1_from_term, valid_s1 && !$past(valid_s1), $past(in_acc && in_term), "stage 1 loaded without a terminator")

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response line decoder testbench
// Streams ASCII response lines into the decoder, predicts every scaled
// reading from a line model of its own and checks each result word in order.
// ----------------------------------------------------------------------------
module tb;
	import obdrld_pkg::*;

	// PID code text, pair k selects quantity k
	localparam logic [8*28-1:0] PID_TEXT = "0C0D050F11040B2F0EA44261625E";
	localparam int MAX_SHOWN = 40;

	typedef struct {
		quantity_t          qty;
		logic signed [15:0] value;
	} reading_t;

	logic clk;
	logic arst_n;

	obdrld_char_if char_bus ();
	obdrld_res_if  reading_bus ();

	obd_response_line_decoder_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_ch (char_bus),
		.res_ch  (reading_bus)
	);

	// readings still owed by the decoder, oldest first
	reading_t readings_due[$];

	// state of the line being received
	logic       ln_seen;
	logic [7:0] ln_chars [KEEP_CHARS];
	logic [3:0] ln_count;
	logic [3:0] ln_len;

	int  chars_sent;
	int  lines_sent;
	int  readings_predicted;
	int  readings_checked;
	int  mismatches;
	bit  gaps_on;
	bit  stalls_on;
	int  stall_left;

	// ------------------------------------------------------------------
	// Clock and time limit
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("Timeout: %0d readings still owed", readings_due.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------
	// Line model
	// ------------------------------------------------------------------
	function automatic bit blank_char(input logic [7:0] c);
		return c inside {CHAR_SPACE, CHAR_TAB, CHAR_VT, CHAR_FF};
	endfunction

	function automatic bit term_char(input logic [7:0] c);
		return c inside {CHAR_CR, CHAR_LF, CHAR_PROMPT};
	endfunction

	// value of one hex digit; anything else reads as zero
	function automatic int nibble(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39)
			return c - 8'h30;
		if (c >= 8'h41 && c <= 8'h46)
			return c - 8'h41 + 10;
		if (c >= 8'h61 && c <= 8'h66)
			return c - 8'h61 + 10;
		return 0;
	endfunction

	function automatic logic [7:0] pid_char(input int k, input int j);
		return PID_TEXT[8*(27 - (2*k + j)) +: 8];
	endfunction

	function automatic int pid_index(input logic [7:0] c0, input logic [7:0] c1);
		for (int k = 0; k < NUM_PIDS; k++)
			if (c0 == pid_char(k, 0) && c1 == pid_char(k, 1))
				return k;
		return -1;
	endfunction

	function automatic logic signed [15:0] scale_reading(input quantity_t q, input int a,
			input int b);
		int ab;
		int v;
		ab = a * 256 + b;
		case (q)
			QTY_RPM:                          v = ab / 4;
			QTY_SPEED, QTY_MAP:               v = a;
			QTY_COOLANT, QTY_INTAKE:          v = a - 40;
			QTY_THROTTLE, QTY_LOAD, QTY_FUEL: v = (a * 100) / 255;
			QTY_TIMING:                       v = a / 2 - 64;
			QTY_GEAR:                         v = a % 16;
			QTY_VOLT:                         v = ab / 100;
			QTY_DEMAND, QTY_TORQUE:           v = a - 125;
			default:                          v = ab / 2;
		endcase
		return v[15:0];
	endfunction

	function automatic void clear_line_state();
		ln_seen  = 1'b0;
		ln_count = 4'd0;
		ln_len   = 4'd0;
		for (int i = 0; i < KEEP_CHARS; i++)
			ln_chars[i] = 8'h00;
	endfunction

	// advance the line model by one accepted character
	function automatic void take_char(input logic [7:0] c);
		int k;
		int a;
		int b;
		reading_t r;
		if (term_char(c)) begin
			if (ln_seen && ln_len >= LEN_MIN && ln_chars[0] == CHAR_4 &&
					ln_chars[1] == CHAR_1) begin
				k = pid_index(ln_chars[2], ln_chars[3]);
				if (k >= 0) begin
					a = nibble(ln_chars[4]) * 16 + nibble(ln_chars[5]);
					b = (ln_len >= LEN_FULL) ? nibble(ln_chars[6]) * 16 + nibble(ln_chars[7]) : 0;
					r.qty   = quantity_t'(k[3:0]);
					r.value = scale_reading(r.qty, a, b);
					readings_due.push_back(r);
					readings_predicted++;
				end
			end
			clear_line_state();
			lines_sent++;
			return;
		end
		// drop leading blanks
		if (!ln_seen && blank_char(c))
			return;
		ln_seen = 1'b1;
		if (ln_count < KEEP_CHARS)
			ln_chars[ln_count] = c;
		if (ln_count < LEN_MAX)
			ln_count++;
		if (!blank_char(c))
			ln_len = ln_count;
	endfunction

	// ------------------------------------------------------------------
	// Result side: random stalls and in-order check
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("Mismatch at %0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		reading_t r;
		if (arst_n && reading_bus.valid === 1'b1 && reading_bus.ready === 1'b1) begin
			if (readings_due.size() == 0) begin
				report_mismatch($sformatf("unexpected reading qty %0d value %0d",
					reading_bus.quantity, reading_bus.value));
			end else begin
				r = readings_due.pop_front();
				readings_checked++;
				if (reading_bus.quantity !== r.qty)
					report_mismatch($sformatf("quantity %0d, want %0d",
						reading_bus.quantity, r.qty));
				if (reading_bus.value !== r.value)
					report_mismatch($sformatf("value %0d, want %0d (qty %0d)",
						reading_bus.value, r.value, r.qty));
			end
		end
		// hold ready low for the rest of a stall burst, or maybe start one
		if (!arst_n) begin
			reading_bus.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			reading_bus.ready <= 1'b0;
		end else if (stalls_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 13) - 1;
			reading_bus.ready <= 1'b0;
		end else begin
			reading_bus.ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Character side
	// ------------------------------------------------------------------
	task automatic send_char(input logic [7:0] c);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			char_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		char_bus.valid   <= 1'b1;
		char_bus.char_in <= c;
		do @(posedge clk); while (char_bus.ready !== 1'b1);
		take_char(c);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	// hold the character side until every owed reading is back
	task automatic wait_drained();
		char_bus.valid <= 1'b0;
		while (readings_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [7:0] any_blank();
		case ($urandom_range(0, 3))
			0:       return CHAR_SPACE;
			1:       return CHAR_TAB;
			2:       return CHAR_VT;
			default: return CHAR_FF;
		endcase
	endfunction

	function automatic logic [7:0] any_term();
		case ($urandom_range(0, 2))
			0:       return CHAR_CR;
			1:       return CHAR_LF;
			default: return CHAR_PROMPT;
		endcase
	endfunction

	// hex digit in either letter case
	function automatic logic [7:0] any_hex();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10)
			return 8'h30 + v;
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10;
	endfunction

	// one response line: mostly well formed, the rest noise
	task automatic random_line();
		logic [7:0] bytes_q[$];
		int k;
		int n;
		if ($urandom_range(0, 3) == 0) begin
			n = $urandom_range(0, 12);
			for (int i = 0; i < n; i++)
				bytes_q.push_back($urandom_range(0, 255));
		end else begin
			n = $urandom_range(0, 2);
			for (int i = 0; i < n; i++)
				bytes_q.push_back(any_blank());
			bytes_q.push_back(($urandom_range(0, 11) == 0) ? $urandom_range(0, 255) : CHAR_4);
			bytes_q.push_back(($urandom_range(0, 11) == 0) ? $urandom_range(0, 255) : CHAR_1);
			k = $urandom_range(0, NUM_PIDS - 1);
			case ($urandom_range(0, 11))
				0: begin
					bytes_q.push_back($urandom_range(0, 255));
					bytes_q.push_back($urandom_range(0, 255));
				end
				1: begin
					// lowercase code matches only when both characters are digits
					bytes_q.push_back(pid_char(k, 0) | 8'h20);
					bytes_q.push_back(pid_char(k, 1) | 8'h20);
				end
				default: begin
					bytes_q.push_back(pid_char(k, 0));
					bytes_q.push_back(pid_char(k, 1));
				end
			endcase
			case ($urandom_range(0, 7))
				0:       n = 1;
				1:       n = 2;
				2:       n = 3;
				default: n = 4;
			endcase
			for (int i = 0; i < n; i++)
				bytes_q.push_back(($urandom_range(0, 11) == 0) ? $urandom_range(0, 255) : any_hex());
			if ($urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++)
					bytes_q.push_back($urandom_range(0, 255));
			end
			n = $urandom_range(0, 2);
			for (int i = 0; i < n; i++)
				bytes_q.push_back(any_blank());
		end
		bytes_q.push_back(any_term());
		foreach (bytes_q[i])
			send_char(bytes_q[i]);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_blank_lines();
		send_char(CHAR_CR);
		send_text("  ");
		send_char(CHAR_TAB);
		send_char(CHAR_LF);
		send_char(CHAR_VT);
		send_char(CHAR_FF);
		send_char(CHAR_PROMPT);
	endtask

	task automatic test_prefix_and_length();
		send_text("420C1AF8");
		send_char(CHAR_CR);
		// five characters only
		send_text("410C1");
		send_char(CHAR_CR);
		// six characters: byte B reads as zero
		send_text("410D7F");
		send_char(CHAR_LF);
	endtask

	task automatic test_pid_codes();
		for (int k = 0; k < NUM_PIDS; k++) begin
			send_text("41");
			send_char(pid_char(k, 0));
			send_char(pid_char(k, 1));
			if (k % 2 == 0)
				send_text("FFFF");
			else
				send_text("00");
			case (k % 3)
				0:       send_char(CHAR_CR);
				1:       send_char(CHAR_LF);
				default: send_char(CHAR_PROMPT);
			endcase
		end
		send_text("410c1234");
		send_char(CHAR_CR);
		send_text("41FF1234");
		send_char(CHAR_CR);
	endtask

	task automatic test_data_digits();
		send_text("410Cffff");
		send_char(CHAR_CR);
		send_text("410Ca0B7");
		send_char(CHAR_CR);
		send_text("410DZZ");
		send_char(CHAR_CR);
		send_text("4142g1G2");
		send_char(CHAR_PROMPT);
	endtask

	task automatic test_trim_and_long();
		send_char(CHAR_TAB);
		send_text("  410C1AF8999  ");
		send_char(CHAR_FF);
		send_char(CHAR_CR);
		// long enough to saturate both lengths
		send_text("415E1AF8XXXXXXXXXXXXXXXX");
		send_char(CHAR_LF);
		// inner blank kept as a data character
		send_text("410C12 4 ");
		send_char(CHAR_VT);
		send_char(CHAR_CR);
	endtask

	task automatic test_odd_bytes();
		send_text("410D");
		send_char(8'hFF);
		send_char(8'h00);
		send_char(CHAR_CR);
		send_char(8'h00);
		send_char(CHAR_CR);
		send_text("4142");
		send_char(8'h80);
		send_text("F");
		send_char(8'h7F);
		send_text("F");
		send_char(CHAR_LF);
	endtask

	task automatic test_random_traffic(input int n_chars, input int n_readings);
		int c0;
		int r0;
		c0 = chars_sent;
		r0 = readings_predicted;
		while (chars_sent - c0 < n_chars || readings_predicted - r0 < n_readings)
			random_line();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n              = 1'b0;
		char_bus.valid      = 1'b0;
		char_bus.char_in    = 8'h00;
		reading_bus.ready   = 1'b0;
		chars_sent          = 0;
		lines_sent          = 0;
		readings_predicted  = 0;
		readings_checked    = 0;
		mismatches          = 0;
		stall_left          = 0;
		gaps_on             = 1'b1;
		stalls_on           = 1'b1;
		clear_line_state();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_blank_lines();
		test_prefix_and_length();
		test_pid_codes();
		test_data_digits();
		test_trim_and_long();
		test_odd_bytes();
		test_random_traffic(800, 30);
		wait_drained();
		test_random_traffic(450, 20);
		// last stretch runs back to back on both sides
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		test_random_traffic(300, 15);
		wait_drained();

		$display("Covered all 14 PID codes, blank, short, long and noisy lines: %0d chars, %0d lines",
			chars_sent, lines_sent);
		$display("Readings checked: %0d, mismatches: %0d", readings_checked, mismatches);
		if (mismatches == 0 && readings_due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
